FILE: design/even_odd_scanline_span_fill_top_defines.svh
// Assertion helpers used by the top-level RTL file.
`ifndef EVEN_ODD_SCANLINE_SPAN_FILL_TOP_DEFINES_SVH
`define EVEN_ODD_SCANLINE_SPAN_FILL_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define ESF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ESF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/esf_pkg.sv
`default_nettype none
package esf_pkg;

    localparam int WORLD_MAX = 65535;

    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_BOUND  = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic [2:0] REG_SCALE_SIDE   = 3'd0;
    localparam logic [2:0] REG_PIXEL_OFFSET = 3'd1;
    localparam logic [2:0] REG_ROW_WIDTH    = 3'd2;
    localparam logic [2:0] REG_LAND_RINGS   = 3'd3;
    localparam logic [2:0] REG_LAKE_RINGS   = 3'd4;

    // floor(p / 65535) for p below 2^29: p = h*65535 + (h + l), h + l < 2*65535
    function automatic logic [13:0] scale_div(input logic [28:0] p);
        logic [12:0] h;
        logic [16:0] t;
        h = p[28:16];
        t = {4'b0, h} + {1'b0, p[15:0]};
        scale_div = {1'b0, h} + ((t >= 17'(WORLD_MAX)) ? 14'd1 : 14'd0);
    endfunction

endpackage
`default_nettype wire

FILE: design/even_odd_scanline_span_fill_top.sv
// Vertex and ring-boundary writes leave busy low.
// A row query walks every edge of every ring, runs the serial 32-step divider
// once per crossing, insertion-sorts the n crossings in memory and then scans
// the crossing pairs; one result strobe per span (one with no span if none), then busy drops.
// Results are strobed for one cycle on o_valid; the receiver cannot stall.
// Reset clears control state and presets registers; vertex/boundary stores are undefined.
`default_nettype none
module even_odd_scanline_span_fill_top #(
    parameter int MAX_CROSSINGS = 128,
    parameter int MAX_VERTICES  = 4096,
    parameter int MAX_RINGS     = 256,
    parameter int MAX_ROW_WIDTH = 1280
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic        i_layer,
    input  wire logic [11:0] i_index,
    input  wire logic [15:0] i_vertex_x,
    input  wire logic [15:0] i_vertex_y,
    input  wire logic [12:0] i_boundary,
    input  wire logic [15:0] i_world_row,
    output logic             o_valid,
    output logic [10:0]      o_span_start,
    output logic [10:0]      o_span_end,
    output logic             o_span_valid,
    output logic             o_last
);
    import esf_pkg::*;
    `include "even_odd_scanline_span_fill_top_defines.svh"

    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int RAW = $clog2(MAX_RINGS + 1);
    localparam int CAW = (MAX_CROSSINGS > 2) ? $clog2(MAX_CROSSINGS) : 1;
    localparam int CCW = $clog2(MAX_CROSSINGS + 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_RB_A, ST_RB_B, ST_RB_C, ST_V0, ST_V1, ST_V2, ST_CHK,
        ST_MUL, ST_DIVS, ST_DIV, ST_EVEN, ST_SORT_I, ST_SORT_V, ST_SORT_R,
        ST_SORT_C, ST_SORT_W, ST_P_A, ST_P_B, ST_P_C, ST_P_D, ST_FIN
    } t_state;

    t_state r_state;

    logic [12:0] r_scale_side;
    logic [13:0] r_pixel_offset;
    logic [10:0] r_row_width;
    logic [8:0]  r_land_rings;
    logic [8:0]  r_lake_rings;

    logic           r_layer;
    logic [15:0]    r_row;
    logic [RAW-1:0] r_rings;
    logic [RAW-1:0] r_ring;
    logic [VCW-1:0] r_a, r_b, r_i;
    logic [15:0]    r_x0, r_y0, r_x1, r_y1;
    logic signed [16:0] r_dr, r_dx, r_dy;
    logic signed [33:0] r_prod;
    logic [CCW-1:0] r_n, r_k;
    logic [15:0]    r_v;
    logic [28:0]    r_sprod;
    logic [13:0]    r_sa;
    logic           r_have;
    logic [10:0]    r_pa, r_pb;

    // memory ports
    logic              vt_we, rb_we, cb_we;
    logic [VAW:0]      vt_waddr, vt_raddr;
    logic [RAW:0]      rb_waddr, rb_raddr;
    logic [CAW-1:0]    cb_waddr, cb_raddr;
    logic [31:0]       vt_rdata;
    logic [12:0]       rb_rdata;
    logic [15:0]       cb_wdata, cb_rdata;

    logic        div_start, div_done;
    logic [31:0] div_quot;
    logic [33:0] prod_mag;
    logic [16:0] dy_mag;

    logic        acc;
    logic        cfg_wr;
    logic [31:0] bnd_ext;
    logic [VCW-1:0] bnd_clamp;
    logic [VCW-1:0] i_next;
    logic [VCW-1:0] j_idx;
    logic        edge_more;
    logic        ring_more;
    logic [CCW-1:0] k_m1;
    logic        crosses;
    logic signed [17:0] sq, xs;
    logic [15:0] x_cl;
    logic signed [15:0] rw_s, sp_a, sp_b, cl_a, cl_b;
    logic [13:0] sb;
    logic        keep;

    assign acc    = start && !busy;
    assign busy   = (r_state != ST_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[4:2])
            REG_SCALE_SIDE:   prdata = 32'(r_scale_side);
            REG_PIXEL_OFFSET: prdata = 32'($signed(r_pixel_offset));
            REG_ROW_WIDTH:    prdata = 32'(r_row_width);
            REG_LAND_RINGS:   prdata = 32'(r_land_rings);
            REG_LAKE_RINGS:   prdata = 32'(r_lake_rings);
            default:          prdata = '0;
        endcase
    end

    assign bnd_ext   = 32'(rb_rdata);
    assign bnd_clamp = (bnd_ext > 32'(MAX_VERTICES)) ? VCW'(MAX_VERTICES) : VCW'(bnd_ext);
    assign i_next    = r_i + VCW'(1);
    assign edge_more = i_next < r_b;
    assign j_idx     = edge_more ? i_next : r_a;
    assign ring_more = (r_ring + RAW'(1)) < r_rings;
    assign k_m1      = r_k - CCW'(1);

    assign crosses = ((r_y0 <= r_row) && (r_row < r_y1)) || ((r_y1 <= r_row) && (r_row < r_y0));

    assign prod_mag = r_prod[33] ? 34'(-r_prod) : 34'(r_prod);
    assign dy_mag   = r_dy[16] ? 17'(-r_dy) : 17'(r_dy);
    assign sq       = (r_prod[33] ^ r_dy[16]) ? -$signed({2'b0, div_quot[15:0]})
                                              : $signed({2'b0, div_quot[15:0]});
    assign xs       = $signed({2'b0, r_x0}) + sq;
    assign x_cl     = xs[17] ? 16'd0 : (xs[16] ? 16'hFFFF : xs[15:0]);

    // span arithmetic for the pair just read
    assign sb   = scale_div(r_sprod);
    assign rw_s = (32'(r_row_width) < 32'(MAX_ROW_WIDTH)) ? 16'(r_row_width)
                                                          : 16'(MAX_ROW_WIDTH);
    assign sp_a = $signed({2'b0, r_sa}) + $signed({{2{r_pixel_offset[13]}}, r_pixel_offset});
    assign sp_b = $signed({2'b0, sb}) + $signed({{2{r_pixel_offset[13]}}, r_pixel_offset});

    always_comb begin
        cl_a = (sp_a < 0) ? 16'sd0 : sp_a;
        cl_b = (sp_b > rw_s) ? rw_s : sp_b;
        if (!r_layer && (cl_b == cl_a) && (cl_a < rw_s)) begin
            cl_b = cl_a + 16'sd1;
        end
        keep = !((sp_b < 0) || (sp_a >= rw_s)) && (cl_b > cl_a);
    end

    // write ports
    assign vt_we    = acc && (i_kind == KIND_VERTEX) && (32'(i_index) < 32'(MAX_VERTICES));
    assign vt_waddr = {i_layer, VAW'(i_index)};
    assign rb_we    = acc && (i_kind == KIND_BOUND) && (32'(i_index) <= 32'(MAX_RINGS));
    assign rb_waddr = {i_layer, RAW'(i_index)};

    always_comb begin
        vt_raddr = {r_layer, r_i[VAW-1:0]};
        rb_raddr = {r_layer, r_ring};
        cb_raddr = r_k[CAW-1:0];
        cb_we    = 1'b0;
        cb_waddr = r_k[CAW-1:0];
        cb_wdata = r_v;
        div_start = 1'b0;
        unique case (r_state)
            ST_RB_B:  rb_raddr = {r_layer, r_ring + RAW'(1)};
            ST_V1:    vt_raddr = {r_layer, j_idx[VAW-1:0]};
            ST_DIVS:  div_start = 1'b1;
            ST_DIV: begin
                cb_we    = div_done && (r_n < CCW'(MAX_CROSSINGS));
                cb_waddr = r_n[CAW-1:0];
                cb_wdata = x_cl;
            end
            ST_SORT_I: cb_raddr = r_i[CAW-1:0];
            ST_SORT_R: cb_raddr = k_m1[CAW-1:0];
            ST_SORT_C: begin
                cb_we    = cb_rdata > r_v;
                cb_wdata = cb_rdata;
            end
            ST_SORT_W: cb_we = 1'b1;
            ST_P_B:   cb_raddr = CAW'(r_k + CCW'(1));
            default: ;
        endcase
    end

    esf_ram #(.WIDTH(32), .DEPTH(2 << VAW)) u_vertex_ram (
        .i_clk(i_clk), .i_we(vt_we), .i_waddr(vt_waddr),
        .i_wdata({i_vertex_x, i_vertex_y}), .i_raddr(vt_raddr), .o_rdata(vt_rdata)
    );

    esf_ram #(.WIDTH(13), .DEPTH(2 << RAW)) u_bound_ram (
        .i_clk(i_clk), .i_we(rb_we), .i_waddr(rb_waddr),
        .i_wdata(i_boundary), .i_raddr(rb_raddr), .o_rdata(rb_rdata)
    );

    esf_ram #(.WIDTH(16), .DEPTH(1 << CAW)) u_cross_ram (
        .i_clk(i_clk), .i_we(cb_we), .i_waddr(cb_waddr),
        .i_wdata(cb_wdata), .i_raddr(cb_raddr), .o_rdata(cb_rdata)
    );

    esf_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(prod_mag[31:0]), .i_divisor(dy_mag[15:0]),
        .o_done(div_done), .o_quot(div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_scale_side   <= 13'd1280;
            r_pixel_offset <= '0;
            r_row_width    <= 11'd1280;
            r_land_rings   <= '0;
            r_lake_rings   <= '0;
            r_have         <= 1'b0;
            r_n            <= '0;
            o_valid        <= 1'b0;
            o_last         <= 1'b0;
            o_span_valid   <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (cfg_wr) begin
                unique case (paddr[4:2])
                    REG_SCALE_SIDE:   r_scale_side   <= pwdata[12:0];
                    REG_PIXEL_OFFSET: r_pixel_offset <= pwdata[13:0];
                    REG_ROW_WIDTH:    r_row_width    <= pwdata[10:0];
                    REG_LAND_RINGS:   r_land_rings   <= pwdata[8:0];
                    REG_LAKE_RINGS:   r_lake_rings   <= pwdata[8:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (acc && (i_kind == KIND_QUERY)) begin
                        r_layer <= i_layer;
                        r_row   <= i_world_row;
                        r_ring  <= '0;
                        r_n     <= '0;
                        r_have  <= 1'b0;
                        if (i_layer) begin
                            r_rings <= (32'(r_lake_rings) > 32'(MAX_RINGS)) ?
                                       RAW'(MAX_RINGS) : RAW'(r_lake_rings);
                            r_state <= (r_lake_rings == '0) ? ST_EVEN : ST_RB_A;
                        end else begin
                            r_rings <= (32'(r_land_rings) > 32'(MAX_RINGS)) ?
                                       RAW'(MAX_RINGS) : RAW'(r_land_rings);
                            r_state <= (r_land_rings == '0) ? ST_EVEN : ST_RB_A;
                        end
                    end
                end
                ST_RB_A: r_state <= ST_RB_B;
                ST_RB_B: begin
                    r_a     <= bnd_clamp;
                    r_i     <= bnd_clamp;
                    r_state <= ST_RB_C;
                end
                ST_RB_C: begin
                    r_b <= bnd_clamp;
                    if (r_a < bnd_clamp) begin
                        r_state <= ST_V0;
                    end else if (ring_more) begin
                        r_ring  <= r_ring + RAW'(1);
                        r_state <= ST_RB_A;
                    end else begin
                        r_state <= ST_EVEN;
                    end
                end
                ST_V0: r_state <= ST_V1;
                ST_V1: begin
                    r_x0    <= vt_rdata[31:16];
                    r_y0    <= vt_rdata[15:0];
                    r_state <= ST_V2;
                end
                ST_V2: begin
                    r_x1    <= vt_rdata[31:16];
                    r_y1    <= vt_rdata[15:0];
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    r_dr <= $signed({1'b0, r_row}) - $signed({1'b0, r_y0});
                    r_dx <= $signed({1'b0, r_x1}) - $signed({1'b0, r_x0});
                    r_dy <= $signed({1'b0, r_y1}) - $signed({1'b0, r_y0});
                    if (crosses) begin
                        r_state <= ST_MUL;
                    end else if (edge_more) begin
                        r_i     <= i_next;
                        r_state <= ST_V0;
                    end else if (ring_more) begin
                        r_ring  <= r_ring + RAW'(1);
                        r_state <= ST_RB_A;
                    end else begin
                        r_state <= ST_EVEN;
                    end
                end
                ST_MUL: begin
                    r_prod  <= r_dr * r_dx;
                    r_state <= ST_DIVS;
                end
                ST_DIVS: r_state <= ST_DIV;
                ST_DIV: begin
                    if (div_done) begin
                        if (r_n < CCW'(MAX_CROSSINGS)) begin
                            r_n <= r_n + CCW'(1);
                        end
                        if (edge_more) begin
                            r_i     <= i_next;
                            r_state <= ST_V0;
                        end else if (ring_more) begin
                            r_ring  <= r_ring + RAW'(1);
                            r_state <= ST_RB_A;
                        end else begin
                            r_state <= ST_EVEN;
                        end
                    end
                end
                ST_EVEN: begin
                    // drop the odd crossing
                    r_n     <= {r_n[CCW-1:1], 1'b0};
                    r_i     <= VCW'(1);
                    r_state <= ST_SORT_I;
                end
                ST_SORT_I: begin
                    r_k <= CCW'(r_i);
                    if (32'(r_i) >= 32'(r_n)) begin
                        r_k     <= '0;
                        r_state <= ST_P_A;
                    end else begin
                        r_state <= ST_SORT_V;
                    end
                end
                ST_SORT_V: begin
                    r_v     <= cb_rdata;
                    r_state <= ST_SORT_R;
                end
                ST_SORT_R: r_state <= ST_SORT_C;
                ST_SORT_C: begin
                    if (cb_rdata > r_v) begin
                        r_k     <= k_m1;
                        r_state <= (k_m1 == '0) ? ST_SORT_W : ST_SORT_R;
                    end else begin
                        r_state <= ST_SORT_W;
                    end
                end
                ST_SORT_W: begin
                    r_i     <= r_i + VCW'(1);
                    r_state <= ST_SORT_I;
                end
                ST_P_A: begin
                    r_state <= ({1'b0, r_k} + (CCW + 1)'(1) < {1'b0, r_n}) ? ST_P_B : ST_FIN;
                end
                ST_P_B: begin
                    r_sprod <= 29'(cb_rdata * r_scale_side);
                    r_state <= ST_P_C;
                end
                ST_P_C: begin
                    r_sa    <= scale_div(r_sprod);
                    r_sprod <= 29'(cb_rdata * r_scale_side);
                    r_state <= ST_P_D;
                end
                ST_P_D: begin
                    if (keep) begin
                        if (r_have) begin
                            // older span is not the last
                            o_valid      <= 1'b1;
                            o_span_valid <= 1'b1;
                            o_last       <= 1'b0;
                            o_span_start <= r_pa;
                            o_span_end   <= r_pb;
                        end
                        r_have <= 1'b1;
                        r_pa   <= cl_a[10:0];
                        r_pb   <= cl_b[10:0];
                    end
                    r_k     <= r_k + CCW'(2);
                    r_state <= ST_P_A;
                end
                ST_FIN: begin
                    o_valid      <= 1'b1;
                    o_last       <= 1'b1;
                    o_span_valid <= r_have;
                    o_span_start <= r_have ? r_pa : 11'd0;
                    o_span_end   <= r_have ? r_pb : 11'd0;
                    r_state      <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `ESF_ASSERT_NEXT(a_fin_emits_last, i_clk, i_rst_n, r_state == ST_FIN, o_valid && o_last)
    `ESF_ASSERT_IMPL(a_invalid_is_last, i_clk, i_rst_n, o_valid && !o_span_valid, o_last)
    `ESF_ASSERT_IMPL(a_span_nonempty, i_clk, i_rst_n, o_valid && o_span_valid,
                     o_span_start < o_span_end)
    `ESF_ASSERT_IMPL(a_even_count, i_clk, i_rst_n, r_state == ST_SORT_I, !r_n[0])
endmodule
`default_nettype wire

FILE: design/esf_ram.sv
`default_nettype none
module esf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: design/esf_div.sv
`default_nettype none
module esf_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [15:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quot
);
    logic [16:0] r_rem;
    logic [31:0] r_quot;
    logic [15:0] r_div;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [16:0] rem_sh;
    logic        fits;

    assign rem_sh = {r_rem[15:0], r_quot[31]};
    assign fits   = rem_sh >= {1'b0, r_div};
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_quot <= i_dividend;
                r_div  <= i_divisor;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                // one quotient bit per cycle
                r_rem  <= fits ? (rem_sh - {1'b0, r_div}) : rem_sh;
                r_quot <= {r_quot[30:0], fits};
                r_cnt  <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: sim/tb_even_odd_scanline_span_fill_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_even_odd_scanline_span_fill_top;
    import esf_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int NUM_VERT   = 4096;
    localparam int NUM_RINGS  = 256;
    localparam int ROW_MAX    = 1280;
    localparam int CROSS_MAX  = 128;
    localparam longint CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [1:0]  kind;
        logic        layer;
        logic [11:0] index;
        logic [15:0] vx;
        logic [15:0] vy;
        logic [12:0] bnd;
        logic [15:0] row;
    } cmd_t;

    typedef struct {
        logic [10:0] span_start;
        logic [10:0] span_end;
        logic        span_valid;
        logic        last;
    } span_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_kind = '0;
    logic        i_layer = 1'b0;
    logic [11:0] i_index = '0;
    logic [15:0] i_vertex_x = '0;
    logic [15:0] i_vertex_y = '0;
    logic [12:0] i_boundary = '0;
    logic [15:0] i_world_row = '0;
    logic        o_valid;
    logic [10:0] o_span_start;
    logic [10:0] o_span_end;
    logic        o_span_valid;
    logic        o_last;

    even_odd_scanline_span_fill_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .i_kind(i_kind), .i_layer(i_layer), .i_index(i_index),
        .i_vertex_x(i_vertex_x), .i_vertex_y(i_vertex_y),
        .i_boundary(i_boundary), .i_world_row(i_world_row),
        .o_valid(o_valid), .o_span_start(o_span_start), .o_span_end(o_span_end),
        .o_span_valid(o_span_valid), .o_last(o_last)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the block state
    logic [15:0]        vert_x[2][NUM_VERT];
    logic [15:0]        vert_y[2][NUM_VERT];
    logic [12:0]        ring_bnd[2][NUM_RINGS + 1];
    logic [12:0]        side_reg = 13'd1280;
    logic signed [13:0] offset_reg = '0;
    logic [10:0]        width_reg = 11'd1280;
    logic [8:0]         rings_reg[2] = '{9'd0, 9'd0};

    cmd_t  pending_cmds[$];
    span_t expected_spans[$];
    int    gap_left = 0;
    int    errors = 0;
    int    queries_sent = 0;
    int    spans_seen = 0;
    longint cycles = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void predict_spans(cmd_t c);
        int      xs[$];
        int      nrings, a, b, j;
        longint  y0, y1, x0, x1, xc, rw, sa, sb, rowv;
        span_t   s;
        int      made;
        if (c.kind == KIND_VERTEX) begin
            vert_x[c.layer][c.index] = c.vx;
            vert_y[c.layer][c.index] = c.vy;
            return;
        end
        if (c.kind == KIND_BOUND) begin
            if (c.index <= NUM_RINGS) ring_bnd[c.layer][c.index] = c.bnd;
            return;
        end
        if (c.kind != KIND_QUERY) return;
        rowv = c.row;
        nrings = rings_reg[c.layer] > NUM_RINGS ? NUM_RINGS : rings_reg[c.layer];
        for (int r = 0; r < nrings; r++) begin
            a = ring_bnd[c.layer][r] > NUM_VERT ? NUM_VERT : ring_bnd[c.layer][r];
            b = ring_bnd[c.layer][r+1] > NUM_VERT ? NUM_VERT : ring_bnd[c.layer][r+1];
            for (int i = a; i < b; i++) begin
                j = (i + 1 < b) ? i + 1 : a;
                y0 = vert_y[c.layer][i];
                y1 = vert_y[c.layer][j];
                if (y0 == y1) continue;
                if (!((y0 <= rowv && rowv < y1) || (y1 <= rowv && rowv < y0))) continue;
                x0 = vert_x[c.layer][i];
                x1 = vert_x[c.layer][j];
                xc = x0 + ((rowv - y0) * (x1 - x0)) / (y1 - y0);
                if (xc < 0) xc = 0;
                if (xc > WORLD_MAX) xc = WORLD_MAX;
                if (xs.size() < CROSS_MAX) xs.push_back(int'(xc));
            end
        end
        if (xs.size() % 2 == 1) void'(xs.pop_back());
        xs.sort();
        rw = width_reg < ROW_MAX ? width_reg : ROW_MAX;
        made = 0;
        for (int k = 0; k + 1 < xs.size(); k += 2) begin
            sa = (longint'(xs[k]) * longint'(side_reg)) / WORLD_MAX + longint'(offset_reg);
            sb = (longint'(xs[k+1]) * longint'(side_reg)) / WORLD_MAX + longint'(offset_reg);
            if (sb < 0 || sa >= rw) continue;
            if (sa < 0) sa = 0;
            if (sb > rw) sb = rw;
            if (c.layer == 1'b0 && sb == sa && sa < rw) sb = sa + 1;
            if (sb <= sa) continue;
            s.span_start = sa[10:0];
            s.span_end   = sb[10:0];
            s.span_valid = 1'b1;
            s.last       = 1'b0;
            expected_spans.push_back(s);
            made++;
        end
        if (made == 0) begin
            s = '{11'd0, 11'd0, 1'b0, 1'b1};
            expected_spans.push_back(s);
        end else begin
            expected_spans[expected_spans.size() - 1].last = 1'b1;
        end
    endfunction

    // driver: hold the transaction until accepted, then advance
    always @(posedge i_clk) begin
        cmd_t c;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                c.kind = i_kind; c.layer = i_layer; c.index = i_index;
                c.vx = i_vertex_x; c.vy = i_vertex_y; c.bnd = i_boundary;
                c.row = i_world_row;
                predict_spans(c);
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    c = pending_cmds.pop_front();
                    i_kind <= c.kind; i_layer <= c.layer; i_index <= c.index;
                    i_vertex_x <= c.vx; i_vertex_y <= c.vy; i_boundary <= c.bnd;
                    i_world_row <= c.row;
                    start <= 1'b1;
                    gap_left <= pick_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        span_t e;
        if (i_rst_n && o_valid) begin
            spans_seen++;
            if (expected_spans.size() == 0) begin
                errors++;
                $display("%0t: unexpected span start=%0d end=%0d valid=%0d last=%0d",
                         $time, o_span_start, o_span_end, o_span_valid, o_last);
            end else begin
                e = expected_spans.pop_front();
                if (o_span_start !== e.span_start) begin
                    errors++;
                    $display("%0t: span_start expected %0d actual %0d",
                             $time, e.span_start, o_span_start);
                end
                if (o_span_end !== e.span_end) begin
                    errors++;
                    $display("%0t: span_end expected %0d actual %0d",
                             $time, e.span_end, o_span_end);
                end
                if (o_span_valid !== e.span_valid) begin
                    errors++;
                    $display("%0t: span_valid expected %0d actual %0d",
                             $time, e.span_valid, o_span_valid);
                end
                if (o_last !== e.last) begin
                    errors++;
                    $display("%0t: last expected %0d actual %0d", $time, e.last, o_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("even_odd_scanline_span_fill_top: mismatch");
            $finish;
        end
    end

    task automatic push_cmd(logic [1:0] kind, logic layer, logic [11:0] index,
                            logic [15:0] vx, logic [15:0] vy, logic [12:0] bnd,
                            logic [15:0] row);
        cmd_t c;
        c = '{kind, layer, index, vx, vy, bnd, row};
        if (kind == KIND_QUERY) queries_sent++;
        pending_cmds.push_back(c);
    endtask

    task automatic query(logic layer, logic [15:0] row);
        push_cmd(KIND_QUERY, layer, 12'($urandom), 16'($urandom), 16'($urandom),
                 13'($urandom), row);
    endtask

    // wait until the block is idle with nothing outstanding
    task automatic drain();
        do @(posedge i_clk);
        while (pending_cmds.size() > 0 || start || busy || expected_spans.size() > 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx * 4); pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_SCALE_SIDE:   side_reg = value[12:0];
            REG_PIXEL_OFFSET: offset_reg = value[13:0];
            REG_ROW_WIDTH:    width_reg = value[10:0];
            REG_LAND_RINGS:   rings_reg[0] = value[8:0];
            REG_LAKE_RINGS:   rings_reg[1] = value[8:0];
            default: ;
        endcase
    endtask

    task automatic configure(int side, int offset, int width, int land_k, int lake_k);
        drain();
        reg_write(REG_SCALE_SIDE, 32'(side));
        reg_write(REG_PIXEL_OFFSET, 32'(offset));
        reg_write(REG_ROW_WIDTH, 32'(width));
        reg_write(REG_LAND_RINGS, 32'(land_k));
        reg_write(REG_LAKE_RINGS, 32'(lake_k));
    endtask

    // build ring_k random rings on one layer, then query rows across them
    task automatic random_layout(logic layer, int ring_k);
        int          base, sz;
        logic [15:0] ys[$];
        base = $urandom_range(0, 3900);
        for (int r = 0; r < ring_k; r++) begin
            push_cmd(KIND_BOUND, layer, 12'(r), 16'($urandom), 16'($urandom),
                     13'(base), 16'($urandom));
            sz = $urandom_range(3, 5);
            for (int v = 0; v < sz; v++) begin
                ys.push_back(16'($urandom));
                push_cmd(KIND_VERTEX, layer, 12'(base + v), 16'($urandom),
                         ys[ys.size() - 1], 13'($urandom), 16'($urandom));
            end
            base += sz;
        end
        push_cmd(KIND_BOUND, layer, 12'(ring_k), 16'($urandom), 16'($urandom),
                 13'(base), 16'($urandom));
        if ($urandom_range(0, 3) == 0)
            push_cmd(KIND_UNUSED, layer, 12'($urandom), 16'($urandom), 16'($urandom),
                     13'($urandom), 16'($urandom));
        if ($urandom_range(0, 3) == 0)
            push_cmd(KIND_BOUND, layer, 12'($urandom_range(NUM_RINGS + 1, 4095)),
                     16'($urandom), 16'($urandom), 13'($urandom), 16'($urandom));
        for (int q = 0; q < 3; q++) begin
            if ($urandom_range(0, 1) == 0) query(layer, 16'($urandom));
            else query(layer, ys[$urandom_range(0, ys.size() - 1)]);
        end
    endtask

    initial begin
        int rk;
        int side_tab[7]   = '{4096, 1, 8191, 8191, 1280, 0, 0};
        int offset_tab[7] = '{-1500, 0, 8191, -8192, -4096, 0, 0};
        int width_tab[7]  = '{1280, 1, 2047, 0, 1280, 0, 0};
        for (int l = 0; l < 2; l++)
            for (int i = 0; i < NUM_VERT; i++) begin
                vert_x[l][i] = '0; vert_y[l][i] = '0;
            end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no rings: both layers answer with no span
        configure(1280, 0, 1280, 0, 0);
        query(1'b0, 16'd100);
        query(1'b1, 16'd100);
        push_cmd(KIND_UNUSED, 1'b0, 12'hFFF, 16'hFFFF, 16'hFFFF, 13'h1FFF, 16'hFFFF);
        push_cmd(KIND_BOUND, 1'b0, 12'd300, 16'd0, 16'd0, 13'd5, 16'd0);

        // zigzag land ring at the list end; its end bound saturates, and nine copies
        // of it overflow the crossing buffer
        for (int t = 0; t < 16; t++)
            push_cmd(KIND_VERTEX, 1'b0, 12'(4080 + t), 16'(t * 4000 + 500),
                     t[0] ? 16'hFFFF : 16'h0000, 13'($urandom), 16'($urandom));
        for (int r = 0; r < 18; r++)
            push_cmd(KIND_BOUND, 1'b0, 12'(r), 16'($urandom), 16'($urandom),
                     r[0] ? 13'h1FFF : 13'd4080, 16'($urandom));
        configure(1280, 0, 1280, 17, 0);
        query(1'b0, 16'd0);
        query(1'b0, 16'd32767);
        query(1'b0, 16'hFFFF);

        // every crossing lands on column 0
        configure(1, 0, 1280, 17, 0);
        query(1'b0, 16'd100);

        side_tab[5] = $urandom_range(1, 4096);
        offset_tab[5] = $urandom_range(0, 8192) - 4096;
        width_tab[5] = $urandom_range(1, 1280);
        side_tab[6] = $urandom_range(1, 4096);
        offset_tab[6] = $urandom_range(0, 400) - 200;
        width_tab[6] = $urandom_range(600, 1280);
        for (int p = 0; p < 7; p++) begin
            rk = $urandom_range(1, 2);
            configure(side_tab[p], offset_tab[p], width_tab[p],
                      p[0] ? 0 : rk, p[0] ? rk : 0);
            random_layout(p[0], rk);
        end

        drain();
        $display("Ran %0d row queries over 10 register settings; %0d spans checked.",
                 queries_sent, spans_seen);
        if (errors == 0) begin
            $display("even_odd_scanline_span_fill_top: match");
        end else begin
            $display("even_odd_scanline_span_fill_top: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire
